// ===== design/assert_macros.svh =====
// Assertion helpers shared by the parser modules.
// Each macro places one labelled concurrent assertion, sampled on the
// rising clock edge and switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define DSH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the next edge.
`define DSH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/dsh_pkg.sv =====
// ----------------------------------------------------------------------------
// dsh_pkg: shared types and constants for the DTS sync header parser
// Sizes, register indexes, decode tables and the job record that travels
// from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dsh_pkg;

   // Stream framing
   localparam int HEADER_BYTES  = 16;
   localparam int SEARCH_WINDOW = 16384;
   localparam int STORE_DEPTH   = 16;
   localparam int PRIME_BYTES   = 3;
   localparam int SYNC_BYTES    = 4;
   localparam logic [31:0] SYNC_WORD = 32'h7FFE_8001;

   localparam int IDX_W     = $clog2(HEADER_BYTES + 1);
   localparam int CNT_W     = $clog2(SEARCH_WINDOW + 1);
   localparam int STORE_AW  = $clog2(STORE_DEPTH);

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int CHAN_W    = 4;
   localparam int RATE_W    = 16;
   localparam int BPS_W     = 5;
   localparam int FRAME_W   = 15;
   localparam int CHCODE_W  = 6;
   localparam int RTCODE_W  = 4;
   localparam int RSCODE_W  = 3;
   localparam int FSIZE_W   = 14;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam logic [CSR_INDEX_W-1:0] REG_SEARCH_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FIXED_FRAME_SIZE = 2'd1;

   // Header field masks
   localparam logic [7:0] RATE_MASK = 8'h3C;
   localparam logic [7:0] CRC_MASK  = 8'h02;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Decode tables
   localparam logic [CHAN_W-1:0] CHAN_TAB [16] = '{
      4'd1, 4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4,
      4'd4, 4'd5, 4'd6, 4'd6, 4'd6, 4'd7, 4'd8, 4'd8};
   localparam logic [RATE_W-1:0] RATE_TAB [16] = '{
      16'd0,     16'd8000,  16'd16000, 16'd32000,
      16'd0,     16'd0,     16'd11025, 16'd22050,
      16'd44100, 16'd0,     16'd0,     16'd12000,
      16'd24000, 16'd48000, 16'd0,     16'd0};
   localparam logic [BPS_W-1:0] RES_TAB [8] = '{
      5'd16, 5'd16, 5'd20, 5'd20, 5'd0, 5'd24, 5'd24, 5'd0};

   // One unit of work for the back end: a failure or raw header codes
   typedef struct packed {
      logic                fail;
      logic [CHCODE_W-1:0] chan_code;
      logic [RTCODE_W-1:0] rate_code;
      logic [RSCODE_W-1:0] res_code;
      logic [FSIZE_W-1:0]  size_field;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

// ===== design/dsh_front.sv =====
// ----------------------------------------------------------------------------
// dsh_front: sync search and header collection
// Primes the window, scans for the core sync word, gathers header bytes and
// hands a failure or the raw header codes to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsh_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [dsh_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                             req_stall,
   input  wire logic                        search_enable,
   input  wire dsh_pkg::q_status_type       q_status,
   output logic                             push,
   output dsh_pkg::job_type                 push_job
);

   typedef enum logic [1:0] {
      PH_PRIMING = 2'd0,
      PH_SEARCH  = 2'd1,
      PH_COLLECT = 2'd2
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [31:0]                       window_ff, window_in;
   logic [dsh_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [dsh_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [dsh_pkg::BYTE_W-1:0]        hdr_ff [dsh_pkg::STORE_DEPTH];
   logic [dsh_pkg::BYTE_W-1:0]        view   [dsh_pkg::STORE_DEPTH];
   logic                              accept;
   logic [31:0]                       window_shift;
   logic [dsh_pkg::CNT_W-1:0]         count_inc, limit;
   logic [dsh_pkg::IDX_W-1:0]         idx_inc;
   logic [dsh_pkg::RSCODE_W-1:0]      res_code;

   assign req_stall    = q_status.full;
   assign accept       = req_valid && !q_status.full;
   assign window_shift = {window_ff[23:0], req_data_byte};
   assign count_inc    = count_ff + 1'b1;
   assign idx_inc      = idx_ff + 1'b1;
   assign limit        = search_enable ? dsh_pkg::CNT_W'(dsh_pkg::SEARCH_WINDOW)
                                       : dsh_pkg::CNT_W'(1);

   // Header as it stands with the byte now arriving merged in
   always_comb begin
      for (int i = 0; i < dsh_pkg::STORE_DEPTH; i++) begin
         view[i] = (idx_ff == dsh_pkg::IDX_W'(i)) ? req_data_byte : hdr_ff[i];
      end
   end

   assign res_code = ((view[4] & dsh_pkg::CRC_MASK) != 8'h00)
                   ? {view[13][0], view[14][7:6]}
                   : {view[11][0], view[12][7:6]};

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      push      = 1'b0;
      push_job  = '0;
      if (accept) begin
         case (phase_ff)
            PH_SEARCH: begin
               window_in = window_shift;
               if (window_shift == dsh_pkg::SYNC_WORD) begin
                  idx_in   = dsh_pkg::IDX_W'(dsh_pkg::SYNC_BYTES);
                  phase_in = PH_COLLECT;
               end else if (count_inc >= limit) begin
                  phase_in      = PH_PRIMING;
                  idx_in        = '0;
                  count_in      = '0;
                  push          = 1'b1;
                  push_job.fail = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_COLLECT: begin
               idx_in = idx_inc;
               if (idx_inc >= dsh_pkg::IDX_W'(dsh_pkg::HEADER_BYTES)) begin
                  phase_in            = PH_PRIMING;
                  idx_in              = '0;
                  count_in            = '0;
                  push                = 1'b1;
                  push_job.chan_code  = {view[7][3:0], view[8][7:6]};
                  push_job.rate_code  = dsh_pkg::RTCODE_W'((view[8] & dsh_pkg::RATE_MASK) >> 2);
                  push_job.res_code   = res_code;
                  push_job.size_field = {view[5][1:0], view[6], view[7][7:4]};
               end
            end
            default: begin
               // priming; the unused code behaves the same
               window_in = window_shift;
               if (idx_inc >= dsh_pkg::IDX_W'(dsh_pkg::PRIME_BYTES)) begin
                  idx_in   = '0;
                  count_in = '0;
                  phase_in = PH_SEARCH;
               end else begin
                  idx_in   = idx_inc;
                  phase_in = PH_PRIMING;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PRIMING;
         window_ff <= '0;
         idx_ff    <= '0;
         count_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         idx_ff    <= idx_in;
         count_ff  <= count_in;
      end
   end

   // Header bytes past the store are counted but not kept
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_COLLECT &&
          idx_ff < dsh_pkg::IDX_W'(dsh_pkg::STORE_DEPTH)) begin
         hdr_ff[idx_ff[dsh_pkg::STORE_AW-1:0]] <= req_data_byte;
      end
   end

   `DSH_ASSERT_NEXT(a_push_restarts, clock, reset, push, phase_ff == PH_PRIMING && idx_ff == '0, "front: no restart after job")
   `DSH_ASSERT_NOW(a_collect_index, clock, reset, phase_ff == PH_COLLECT, idx_ff >= dsh_pkg::IDX_W'(dsh_pkg::SYNC_BYTES), "front: header index below sync length")

endmodule

`default_nettype wire

// ===== design/dsh_queue.sv =====
// ----------------------------------------------------------------------------
// dsh_queue: short job queue between front and back
// Two-entry FIFO of job records so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsh_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire dsh_pkg::job_type   push_job,
   input  wire logic               pop,
   output dsh_pkg::job_type        pop_job,
   output dsh_pkg::q_status_type   q_status
);

   dsh_pkg::job_type               entry_ff [dsh_pkg::QUEUE_DEPTH];
   logic [dsh_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dsh_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dsh_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign q_status.full  = (count_ff == dsh_pkg::QCNT_W'(dsh_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_job        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == dsh_pkg::QPTR_W'(dsh_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == dsh_pkg::QPTR_W'(dsh_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `DSH_ASSERT_NOW(a_no_overflow, clock, reset, push, !q_status.full, "queue: push while full")
   `DSH_ASSERT_NOW(a_no_underflow, clock, reset, pop, !q_status.empty, "queue: pop while empty")

endmodule

`default_nettype wire

// ===== design/dsh_back.sv =====
// ----------------------------------------------------------------------------
// dsh_back: header decode and result register
// Turns raw header codes into channel count, rate, resolution and frame
// size, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dsh_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dsh_pkg::q_status_type         q_status,
   input  wire dsh_pkg::job_type              pop_job,
   output logic                               pop,
   input  wire logic [dsh_pkg::FRAME_W-1:0]   fixed_frame_size,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_status,
   output logic [dsh_pkg::CHAN_W-1:0]         rsp_channels,
   output logic [dsh_pkg::RATE_W-1:0]         rsp_sample_rate,
   output logic [dsh_pkg::BPS_W-1:0]          rsp_bits_per_sample,
   output logic [dsh_pkg::FRAME_W-1:0]        rsp_frame_bytes
);

   logic                          valid_ff;
   logic                          status_ff,   status_in;
   logic [dsh_pkg::CHAN_W-1:0]    chan_ff,     chan_in;
   logic [dsh_pkg::RATE_W-1:0]    rate_ff,     rate_in;
   logic [dsh_pkg::BPS_W-1:0]     bps_ff,      bps_in;
   logic [dsh_pkg::FRAME_W-1:0]   frame_ff,    frame_in;

   assign pop = !q_status.empty && (!valid_ff || !rsp_stall);

   always_comb begin
      status_in = pop_job.fail;
      chan_in   = '0;
      rate_in   = '0;
      bps_in    = '0;
      frame_in  = '0;
      if (!pop_job.fail) begin
         if (pop_job.chan_code < dsh_pkg::CHCODE_W'(16)) begin
            chan_in = dsh_pkg::CHAN_TAB[pop_job.chan_code[3:0]];
         end
         rate_in  = dsh_pkg::RATE_TAB[pop_job.rate_code];
         bps_in   = dsh_pkg::RES_TAB[pop_job.res_code];
         frame_in = (fixed_frame_size != '0) ? fixed_frame_size
                  : dsh_pkg::FRAME_W'(pop_job.size_field) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         chan_ff   <= chan_in;
         rate_ff   <= rate_in;
         bps_ff    <= bps_in;
         frame_ff  <= frame_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_channels        = chan_ff;
   assign rsp_sample_rate     = rate_ff;
   assign rsp_bits_per_sample = bps_ff;
   assign rsp_frame_bytes     = frame_ff;

   `DSH_ASSERT_NOW(a_fail_zero, clock, reset, valid_ff && status_ff, chan_ff == '0 && rate_ff == '0 && bps_ff == '0 && frame_ff == '0, "back: failure result carries data")

endmodule

`default_nettype wire

// ===== design/dts_sync_header_parser.sv =====
// ----------------------------------------------------------------------------
// dts_sync_header_parser: DTS core frame sync and header parser
// Byte-wide stream in, one decoded header or search failure out per frame.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req_     in         req_valid / req_stall  data_byte [7:0]
//   rsp_     out        rsp_valid / rsp_stall  status, channels, sample_rate,
//                                              bits_per_sample, frame_bytes
//   csr_     in         csr_valid / csr_ready  csr_index [1:0], csr_data [14:0]
//
// One request is taken every cycle while req_stall is low; the front end does
// one shift, one 32-bit compare and one counter step per byte.
// A result is registered first in the job queue and then in the output
// register after the byte that completes it.
// Request stall rises only when the two-entry job queue is full, which
// happens only while the consumer holds rsp_stall.
// Synchronous reset clears the sync window, counters, queue and output valid;
// registers go to search enabled and no fixed frame size.
// ----------------------------------------------------------------------------
`default_nettype none

module dts_sync_header_parser (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [dsh_pkg::BYTE_W-1:0]        req_data_byte,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_status,
   output logic [dsh_pkg::CHAN_W-1:0]             rsp_channels,
   output logic [dsh_pkg::RATE_W-1:0]             rsp_sample_rate,
   output logic [dsh_pkg::BPS_W-1:0]              rsp_bits_per_sample,
   output logic [dsh_pkg::FRAME_W-1:0]            rsp_frame_bytes,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dsh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [dsh_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic                          search_enable_ff;
   logic [dsh_pkg::FRAME_W-1:0]   fixed_frame_size_ff;
   logic                          push, pop;
   dsh_pkg::job_type              push_job, pop_job;
   dsh_pkg::q_status_type         q_status;

   // Registers are always writable; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         search_enable_ff    <= 1'b1;
         fixed_frame_size_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dsh_pkg::REG_SEARCH_ENABLE:    search_enable_ff    <= csr_data[0];
            dsh_pkg::REG_FIXED_FRAME_SIZE: fixed_frame_size_ff <= csr_data[dsh_pkg::FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: prime, search, collect; push one job per frame or failure
   dsh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .search_enable (search_enable_ff),
      .q_status      (q_status),
      .push          (push),
      .push_job      (push_job)
   );

   // Queue: decouple byte intake from result delivery
   dsh_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_status (q_status)
   );

   // Back: table decode and output register
   dsh_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .pop_job             (pop_job),
      .pop                 (pop),
      .fixed_frame_size    (fixed_frame_size_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_channels        (rsp_channels),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_frame_bytes     (rsp_frame_bytes)
   );

endmodule

`default_nettype wire

// ===== tb/sv/dsh_result_checker.sv =====
// ----------------------------------------------------------------------------
// dsh_result_checker: result predictor and scoreboard for the sync parser
// Watches the request, result and register channels, runs its own model of
// the sync search and header decode, and compares every result field.
// ----------------------------------------------------------------------------
module dsh_result_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [dsh_pkg::BYTE_W-1:0]        req_data_byte,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic                              rsp_status,
   input  wire logic [dsh_pkg::CHAN_W-1:0]        rsp_channels,
   input  wire logic [dsh_pkg::RATE_W-1:0]        rsp_sample_rate,
   input  wire logic [dsh_pkg::BPS_W-1:0]         rsp_bits_per_sample,
   input  wire logic [dsh_pkg::FRAME_W-1:0]       rsp_frame_bytes,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [dsh_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [dsh_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                     fail_count,
   output int                                     pending
);

   localparam logic [31:0] CORE_SYNC  = 32'h7FFE_8001;
   localparam int          PRIME_LEN  = 3;
   localparam int          KEPT_BYTES = 16;
   localparam int          HDR_LEN    = dsh_pkg::HEADER_BYTES;
   localparam int          SCAN_LIMIT = dsh_pkg::SEARCH_WINDOW;
   localparam int          MAX_REPORTS = 50;

   // Decode tables, entry 0 in the low bits
   localparam logic [16*4-1:0] CHAN_LUT = {
      4'd8, 4'd8, 4'd7, 4'd6, 4'd6, 4'd6, 4'd5, 4'd4,
      4'd4, 4'd3, 4'd3, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1};
   localparam logic [16*16-1:0] RATE_LUT = {
      16'd0,     16'd0,     16'd48000, 16'd24000,
      16'd12000, 16'd0,     16'd0,     16'd44100,
      16'd22050, 16'd11025, 16'd0,     16'd0,
      16'd32000, 16'd16000, 16'd8000,  16'd0};
   localparam logic [8*5-1:0] RES_LUT = {
      5'd0, 5'd24, 5'd24, 5'd0, 5'd20, 5'd20, 5'd16, 5'd16};

   typedef enum logic [1:0] {PRIMING, SEARCHING, COLLECTING} scan_phase_e;

   typedef struct packed {
      logic                          status;
      logic [dsh_pkg::CHAN_W-1:0]    channels;
      logic [dsh_pkg::RATE_W-1:0]    sample_rate;
      logic [dsh_pkg::BPS_W-1:0]     bits_per_sample;
      logic [dsh_pkg::FRAME_W-1:0]   frame_bytes;
   } header_result_t;

   scan_phase_e                 phase_q;
   logic [31:0]                 window_q;
   logic [7:0]                  hdr_q [KEPT_BYTES];
   int                          idx_q;
   int                          count_q;
   logic                        search_en_q;
   logic [dsh_pkg::FRAME_W-1:0] fixed_size_q;
   header_result_t              expected_q [$];

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < MAX_REPORTS)
         $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
      fail_count++;
   endtask

   // Advance the parser by one stream byte; queue a result when one falls out
   task automatic parse_byte(input logic [7:0] b);
      header_result_t r;
      logic [5:0]     chan_code;
      logic [3:0]     rate_code;
      logic [2:0]     res_code;
      logic [13:0]    size_field;
      int             limit;
      r = '0;
      case (phase_q)
         SEARCHING: begin
            window_q = {window_q[23:0], b};
            if (window_q == CORE_SYNC) begin
               // sync bytes are never decoded, so only the index moves on
               idx_q   = 4;
               phase_q = COLLECTING;
            end else begin
               count_q++;
               // the limit follows the register as it stands now
               limit = search_en_q ? SCAN_LIMIT : 1;
               if (count_q >= limit) begin
                  phase_q  = PRIMING;
                  idx_q    = 0;
                  count_q  = 0;
                  r.status = 1'b1;
                  expected_q.push_back(r);
               end
            end
         end
         COLLECTING: begin
            if (idx_q < KEPT_BYTES)
               hdr_q[idx_q] = b;
            idx_q++;
            if (idx_q >= HDR_LEN) begin
               chan_code  = {hdr_q[7][3:0], hdr_q[8][7:6]};
               rate_code  = hdr_q[8][5:2];
               // CRC present moves the resolution field two bytes on
               res_code   = hdr_q[4][1] ? {hdr_q[13][0], hdr_q[14][7:6]}
                                        : {hdr_q[11][0], hdr_q[12][7:6]};
               size_field = {hdr_q[5][1:0], hdr_q[6], hdr_q[7][7:4]};
               r.channels        = (chan_code < 16) ? CHAN_LUT[chan_code*4 +: 4] : 4'd0;
               r.sample_rate     = RATE_LUT[rate_code*16 +: 16];
               r.bits_per_sample = RES_LUT[res_code*5 +: 5];
               r.frame_bytes     = (fixed_size_q != 0) ? fixed_size_q
                                                       : {1'b0, size_field} + 15'd1;
               expected_q.push_back(r);
               phase_q = PRIMING;
               idx_q   = 0;
               count_q = 0;
            end
         end
         default: begin
            window_q = {window_q[23:0], b};
            idx_q++;
            if (idx_q >= PRIME_LEN) begin
               idx_q   = 0;
               count_q = 0;
               phase_q = SEARCHING;
            end
         end
      endcase
   endtask

   task automatic check_result();
      header_result_t want;
      if (expected_q.size() == 0) begin
         report_mismatch("status of unexpected result", rsp_status, 0);
         return;
      end
      want = expected_q.pop_front();
      if (rsp_status !== want.status)
         report_mismatch("status", rsp_status, want.status);
      if (rsp_channels !== want.channels)
         report_mismatch("channels", rsp_channels, want.channels);
      if (rsp_sample_rate !== want.sample_rate)
         report_mismatch("sample_rate", rsp_sample_rate, want.sample_rate);
      if (rsp_bits_per_sample !== want.bits_per_sample)
         report_mismatch("bits_per_sample", rsp_bits_per_sample, want.bits_per_sample);
      if (rsp_frame_bytes !== want.frame_bytes)
         report_mismatch("frame_bytes", rsp_frame_bytes, want.frame_bytes);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_q      = PRIMING;
         window_q     = '0;
         idx_q        = 0;
         count_q      = 0;
         search_en_q  = 1'b1;
         fixed_size_q = '0;
         fail_count   = 0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dsh_pkg::REG_SEARCH_ENABLE:    search_en_q  = csr_data[0];
               dsh_pkg::REG_FIXED_FRAME_SIZE: fixed_size_q = csr_data;
               default: ;
            endcase
         end
         // results in flight are older than any request taken on this edge
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            parse_byte(req_data_byte);
      end
      pending = expected_q.size();
   end

endmodule

// ===== tb/sv/tb_dts_sync_header_parser.sv =====
// ----------------------------------------------------------------------------
// tb_dts_sync_header_parser: stream-level test of the DTS sync header parser
// Feeds byte streams of framed headers, noise and damaged sync words under
// several register settings, with random gaps on both channels and one long
// result hold-off; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_dts_sync_header_parser;

   localparam int          RESET_CYCLES    = 10;
   localparam int          IDLE_PCT        = 25;
   localparam int          HOLD_OFF_CYCLES = 300;
   // drain margin once results have passed the job queue and output register
   localparam int          DRAIN_CYCLES    = 8;
   // generous bound for about 400 request bytes plus one hold-off
   localparam int          CYCLE_LIMIT     = 20000;
   localparam logic [31:0] CORE_SYNC       = 32'h7FFE_8001;
   localparam int          HDR_LEN         = dsh_pkg::HEADER_BYTES;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [dsh_pkg::BYTE_W-1:0]          req_data_byte = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_status;
   logic [dsh_pkg::CHAN_W-1:0]          rsp_channels;
   logic [dsh_pkg::RATE_W-1:0]          rsp_sample_rate;
   logic [dsh_pkg::BPS_W-1:0]           rsp_bits_per_sample;
   logic [dsh_pkg::FRAME_W-1:0]         rsp_frame_bytes;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dsh_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [dsh_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   int          fail_count;
   int          pending;
   int unsigned cycle_count = 0;
   bit          gaps_on = 1'b1;
   bit          hold_off_go = 1'b0;
   bit          search_on = 1'b1;
   logic [7:0]  hdr_bytes [HDR_LEN];

   dts_sync_header_parser dut (.*);

   dsh_result_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: give up on a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off so the job queue
   // fills and the block has to stall its request channel
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Offer one request byte, with a random gap first; return at the falling
   // edge after the block has taken it
   task automatic send_byte(input logic [7:0] b);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop the request valid, wait for every expected result, then let the
   // pipeline settle so a register write finds the block quiet
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write both registers back to back, holding valid high between them
   task automatic write_config(input logic se, input logic [dsh_pkg::CSR_DATA_W-1:0] ffs);
      csr_valid <= 1'b1;
      csr_index <= dsh_pkg::REG_SEARCH_ENABLE;
      csr_data  <= {{(dsh_pkg::CSR_DATA_W-1){1'b0}}, se};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= dsh_pkg::REG_FIXED_FRAME_SIZE;
      csr_data  <= ffs;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      search_on = se;
   endtask

   // Send the sync word and the rest of the header; fresh draws new content
   task automatic send_header(input bit fresh);
      if (fresh) begin
         for (int i = 4; i < HDR_LEN; i++)
            hdr_bytes[i] = $urandom_range(255);
         // steer half the channel codes into the arrangement table
         if ($urandom_range(1))
            hdr_bytes[7][3:2] = 2'b00;
      end
      for (int i = 3; i >= 0; i--)
         send_byte(CORE_SYNC[i*8 +: 8]);
      for (int i = 4; i < HDR_LEN; i++)
         send_byte(hdr_bytes[i]);
   endtask

   // Mostly well-formed frames with random content, the rest damaged sync
   // words and noise. With search off, keep everything in steps of four
   // bytes so frames stay lined up with the single sync position.
   task automatic send_traffic(input int frames);
      int kind;
      int n;
      for (int f = 0; f < frames; f++) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            n = search_on ? $urandom_range(5) : 0;
            repeat (n) send_byte($urandom_range(255));
            send_header(1'b1);
         end else if (kind < 85) begin
            // corrupt one byte of the sync word
            n = $urandom_range(3);
            for (int i = 3; i >= 0; i--)
               send_byte(CORE_SYNC[i*8 +: 8] ^ ((i == n) ? $urandom_range(1, 255) : 0));
         end else begin
            repeat (4 * $urandom_range(1, 3)) send_byte($urandom_range(255));
         end
      end
      // close on a full header so the next setting starts from priming
      send_header(1'b1);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Search on, header size field: extremes of every decoded field
      write_config(1'b1, '0);
      for (int i = 4; i < HDR_LEN; i++)
         hdr_bytes[i] = 8'hFF;
      // CRC set, codes out of table, largest size field
      send_header(1'b0);
      for (int i = 4; i < HDR_LEN; i++)
         hdr_bytes[i] = 8'h00;
      // CRC clear: resolution from bytes 11 and 12, not the 0xFF pair after
      hdr_bytes[7]  = 8'h03;
      hdr_bytes[8]  = 8'h34;
      hdr_bytes[11] = 8'h01;
      hdr_bytes[12] = 8'h40;
      hdr_bytes[13] = 8'hFF;
      hdr_bytes[14] = 8'hFF;
      send_header(1'b0);
      send_traffic(3);
      wait_idle();

      // Search off, fixed size 16384; first a single-position failure,
      // then frames while the result side holds off for a long stretch
      write_config(1'b0, 15'd16384);
      repeat (4) send_byte(8'h00);
      hold_off_go = 1'b1;
      send_traffic(5);
      wait_idle();

      // Search off mid-scan: the count already meets the new limit
      write_config(1'b1, '0);
      repeat (8) send_byte(8'h00);
      wait_idle();
      write_config(1'b0, '0);
      send_byte(8'h00);
      send_traffic(2);
      wait_idle();

      // Smallest fixed size, no gaps on either side
      write_config(1'b1, 15'd1);
      gaps_on = 1'b0;
      send_traffic(3);
      wait_idle();
      gaps_on = 1'b1;

      // Random settings
      repeat (2) begin
         write_config($urandom_range(1),
                      $urandom_range(1) ? 15'd0 : $urandom_range(1, 16384));
         send_traffic(2);
         wait_idle();
      end

      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
